>>> hdl/jsu_pkg.sv
// Shared types and constants of the JSON string unescaper.
// Used by jsu_front, jsu_queue, jsu_back and json_string_unescaper.
`timescale 1ns / 1ps

package jsu_pkg;

	typedef enum logic [1:0] {
		MODE_SEEK = 2'd0,
		MODE_BODY = 2'd1,
		MODE_ESC  = 2'd2,
		MODE_HEX  = 2'd3
	} mode_t;

	localparam logic [1:0] ST_DATA     = 2'd0;
	localparam logic [1:0] ST_CLOSED   = 2'd1;
	localparam logic [1:0] ST_UNCLOSED = 2'd2;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_N = 8'h6E;
	localparam logic [7:0] CH_R = 8'h72;
	localparam logic [7:0] CH_T = 8'h74;
	localparam logic [7:0] CH_U = 8'h75;
	localparam logic [7:0] CH_NUL = 8'h00;

	localparam logic [15:0] UTF8_ONE_LIMIT = 16'h0080;
	localparam logic [15:0] UTF8_TWO_LIMIT = 16'h0800;
	localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
	localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
	localparam logic [7:0] UTF8_CONT = 8'h80;
	localparam logic [5:0] UTF8_CONT_MASK = 6'h3F;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

	// Results caused by one accepted input byte.
	typedef struct packed {
		logic [1:0] last_idx;
		logic [2:0][7:0] data;
		logic [1:0] status;
	} grp_t;

endpackage

>>> hdl/json_string_unescaper.sv
// Top level of the JSON string unescaper.
// Depends on jsu_pkg, jsu_front, jsu_queue and jsu_back.
`timescale 1ns / 1ps

// One input byte is taken per cycle while the four-entry group queue has room;
// each byte yields zero to three result items, and the back part delivers one
// result item per cycle, while out_stall is low, from a registered output. An
// accepted byte's group is written into the queue, then loaded into the output
// register. A \u escape emits its one to three UTF-8 bytes on the fourth byte
// after the u; byte 0 always yields one item with status 2 and returns the
// parser to seeking the opening quote.
module json_string_unescaper (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic [1:0]  status,
	output logic        run_last
);
	import jsu_pkg::*;

	grp_t grp, head;
	logic grp_push, q_full, q_empty, q_pop, take;

	assign in_stall = q_full;
	assign take = in_valid && !q_full;

	jsu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.in_byte  (in_byte),
		.grp_push (grp_push),
		.grp      (grp)
	);

	jsu_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (grp_push),
		.push_grp (grp),
		.pop      (q_pop),
		.full     (q_full),
		.empty    (q_empty),
		.head     (head)
	);

	jsu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.head      (head),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.status    (status),
		.run_last  (run_last)
	);

	a_ctrl_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_DATA |-> run_last && out_byte == 8'h00)
		else $error("control result not single or carries data");

	a_group_runs: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !run_last |=> out_valid && status == ST_DATA)
		else $error("result group broken");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !grp_push)
		else $error("push into full queue");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |-> q_full && !take)
		else $error("input taken while stalled");

endmodule

>>> hdl/jsu_front.sv
// Front part: parses the byte stream and builds one result group per input byte that yields results.
// Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        in_byte,
	output logic              grp_push,
	output jsu_pkg::grp_t     grp
);
	import jsu_pkg::*;

	mode_t mode_q, mode_d;
	logic [1:0] taken_q, taken_d;
	logic [15:0] cp_q, cp_d;
	logic stop_q, stop_d;

	logic hex_ok;
	logic [3:0] hex_val;
	logic [15:0] cp_acc;
	logic has_res;

	always_comb begin
		hex_ok = 1'b1;
		hex_val = 4'd0;
		if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
			hex_val = 4'(in_byte - 8'h30);
		end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
			hex_val = 4'(in_byte - 8'h57);
		end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
			hex_val = 4'(in_byte - 8'h37);
		end else begin
			hex_ok = 1'b0;
		end
		cp_acc = (!stop_q && hex_ok) ? {cp_q[11:0], hex_val} : cp_q;
	end

	always_comb begin
		mode_d = mode_q;
		if (in_byte == CH_NUL) begin
			mode_d = MODE_SEEK;
		end else begin
			unique case (mode_q)
				MODE_SEEK: if (in_byte == CH_QUOTE) mode_d = MODE_BODY;
				MODE_BODY: begin
					if (in_byte == CH_QUOTE) mode_d = MODE_SEEK;
					else if (in_byte == CH_BSLASH) mode_d = MODE_ESC;
				end
				MODE_ESC: mode_d = (in_byte == CH_U) ? MODE_HEX : MODE_BODY;
				MODE_HEX: if (taken_q == 2'd3) mode_d = MODE_BODY;
				default: mode_d = MODE_SEEK;
			endcase
		end
	end

	always_comb begin
		has_res = 1'b0;
		grp = '0;
		grp.status = ST_DATA;
		taken_d = taken_q;
		cp_d = cp_q;
		stop_d = stop_q;
		if (in_byte == CH_NUL) begin
			has_res = 1'b1;
			grp.status = ST_UNCLOSED;
			taken_d = '0;
			cp_d = '0;
			stop_d = 1'b0;
		end else begin
			unique case (mode_q)
				MODE_SEEK: has_res = 1'b0;
				MODE_BODY: begin
					if (in_byte == CH_QUOTE) begin
						has_res = 1'b1;
						grp.status = ST_CLOSED;
					end else if (in_byte != CH_BSLASH) begin
						has_res = 1'b1;
						grp.data[0] = in_byte;
					end
				end
				MODE_ESC: begin
					has_res = 1'b1;
					case (in_byte)
						CH_N: grp.data[0] = 8'h0A;
						CH_R: grp.data[0] = 8'h0D;
						CH_T: grp.data[0] = 8'h09;
						CH_U: begin
							has_res = 1'b0;
							taken_d = '0;
							cp_d = '0;
							stop_d = 1'b0;
						end
						default: grp.data[0] = in_byte;
					endcase
				end
				MODE_HEX: begin
					if (taken_q == 2'd3) begin
						has_res = 1'b1;
						taken_d = '0;
						cp_d = '0;
						stop_d = 1'b0;
						if (cp_acc < UTF8_ONE_LIMIT) begin
							grp.data[0] = cp_acc[7:0];
						end else if (cp_acc < UTF8_TWO_LIMIT) begin
							grp.last_idx = 2'd1;
							grp.data[0] = UTF8_LEAD2 | {3'b000, cp_acc[10:6]};
							grp.data[1] = UTF8_CONT | {2'b00, cp_acc[5:0] & UTF8_CONT_MASK};
						end else begin
							grp.last_idx = 2'd2;
							grp.data[0] = UTF8_LEAD3 | {4'h0, cp_acc[15:12]};
							grp.data[1] = UTF8_CONT | {2'b00, cp_acc[11:6] & UTF8_CONT_MASK};
							grp.data[2] = UTF8_CONT | {2'b00, cp_acc[5:0] & UTF8_CONT_MASK};
						end
					end else begin
						taken_d = taken_q + 2'd1;
						cp_d = cp_acc;
						stop_d = stop_q | ~hex_ok;
					end
				end
				default: has_res = 1'b0;
			endcase
		end
	end

	assign grp_push = take & has_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SEEK;
			taken_q <= '0;
			cp_q <= '0;
			stop_q <= 1'b0;
		end else if (take) begin
			mode_q <= mode_d;
			taken_q <= taken_d;
			cp_q <= cp_d;
			stop_q <= stop_d;
		end
	end

endmodule

>>> hdl/jsu_queue.sv
// Short queue of result groups between the front and back parts.
// Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  jsu_pkg::grp_t     push_grp,
	input  logic              pop,
	output logic              full,
	output logic              empty,
	output jsu_pkg::grp_t     head
);
	import jsu_pkg::*;

	grp_t mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_q, rd_q;
	logic [QUEUE_CW-1:0] cnt_q;

	assign full = (cnt_q == QUEUE_CW'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wr_q] <= push_grp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) wr_q <= wr_q + 1'b1;
			if (pop && !empty) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + QUEUE_CW'(push && !full) - QUEUE_CW'(pop && !empty);
		end
	end

endmodule

>>> hdl/jsu_back.sv
// Back part: unpacks queued result groups into one result item per cycle while out_stall is low.
// Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  jsu_pkg::grp_t     head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        out_byte,
	output logic [1:0]        status,
	output logic              run_last
);
	import jsu_pkg::*;

	logic [1:0] idx_q;
	logic valid_q;
	logic [7:0] byte_q;
	logic [1:0] status_q;
	logic last_q;
	logic load, at_last;

	assign load = !q_empty && (!valid_q || !out_stall);
	assign at_last = (idx_q == head.last_idx);
	assign pop = load && at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q <= at_last ? 2'd0 : idx_q + 2'd1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= head.data[idx_q];
			status_q <= head.status;
			last_q <= at_last;
		end
	end

	assign out_valid = valid_q;
	assign out_byte = byte_q;
	assign status = status_q;
	assign run_last = last_q;

endmodule

>>> tb/json_string_unescaper_tb.sv
// Testbench for json_string_unescaper: a directed byte table, then random JSON strings.
// Results are checked against a behavioral decoder kept in this file, or against a typed table row.
// Depends on jsu_pkg and the json_string_unescaper RTL.
`timescale 1ns / 1ps

module json_string_unescaper_tb;
	import jsu_pkg::*;

	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_APOS = 8'h27;
	localparam logic [7:0] BYTE_LF = 8'h0A;
	localparam logic [7:0] BYTE_CR = 8'h0D;
	localparam logic [7:0] BYTE_TAB = 8'h09;
	localparam int IDLE_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 90;

	typedef struct packed {
		logic [7:0] data;
		logic [1:0] st;
		logic       last;
	} result_t;

	typedef struct packed {
		logic [7:0] b;
		bit         typed;
		logic [7:0] eb;
		logic [1:0] est;
	} dir_row_t;

	localparam dir_row_t DIR_ROWS [30] = '{
		'{CH_NUL,    1'b1, 8'h00, ST_UNCLOSED},
		'{"x",       1'b0, 8'h00, ST_DATA},
		'{CH_QUOTE,  1'b0, 8'h00, ST_DATA},
		'{8'hFF,     1'b1, 8'hFF, ST_DATA},
		'{8'h01,     1'b1, 8'h01, ST_DATA},
		'{CH_BSLASH, 1'b0, 8'h00, ST_DATA},
		'{CH_N,      1'b0, 8'h00, ST_DATA},
		'{CH_BSLASH, 1'b0, 8'h00, ST_DATA},
		'{"q",       1'b0, 8'h00, ST_DATA},
		'{CH_BSLASH, 1'b0, 8'h00, ST_DATA},
		'{CH_U,      1'b0, 8'h00, ST_DATA},
		'{"F",       1'b0, 8'h00, ST_DATA},
		'{"f",       1'b0, 8'h00, ST_DATA},
		'{"F",       1'b0, 8'h00, ST_DATA},
		'{"F",       1'b0, 8'h00, ST_DATA},
		'{CH_BSLASH, 1'b0, 8'h00, ST_DATA},
		'{CH_U,      1'b0, 8'h00, ST_DATA},
		'{"7",       1'b0, 8'h00, ST_DATA},
		'{"z",       1'b0, 8'h00, ST_DATA},
		'{CH_QUOTE,  1'b0, 8'h00, ST_DATA},
		'{"A",       1'b0, 8'h00, ST_DATA},
		'{CH_QUOTE,  1'b1, 8'h00, ST_CLOSED},
		'{CH_QUOTE,  1'b0, 8'h00, ST_DATA},
		'{CH_BSLASH, 1'b0, 8'h00, ST_DATA},
		'{CH_NUL,    1'b1, 8'h00, ST_UNCLOSED},
		'{CH_QUOTE,  1'b0, 8'h00, ST_DATA},
		'{CH_BSLASH, 1'b0, 8'h00, ST_DATA},
		'{CH_U,      1'b0, 8'h00, ST_DATA},
		'{"1",       1'b0, 8'h00, ST_DATA},
		'{CH_NUL,    1'b1, 8'h00, ST_UNCLOSED}
	};

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] in_byte;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic [1:0] status;
	logic       run_last;

	result_t    decoded_q[$];
	result_t    step_q[$];
	logic [7:0] stream_q[$];

	mode_t       pmode = MODE_SEEK;
	logic [1:0]  hex_seen = '0;
	logic [15:0] cp_acc = '0;
	logic        hex_halted = 1'b0;

	int errors = 0;
	int idle_cycles = 0;
	int stall_left = 0;
	int calm_left = 0;
	bit no_gaps = 1'b0;

	json_string_unescaper u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.status(status),
		.run_last(run_last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch on %s at %0t: got %0h, expected %0h", what, $realtime, got, want);
		errors++;
	endtask

	function automatic void put_res(input logic [7:0] data, input logic [1:0] st);
		step_q.insert(step_q.size(), '{data, st, 1'b0});
	endfunction

	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
		if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
		if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
		return 5'd0;
	endfunction

	function automatic void emit_utf8(input logic [15:0] cp);
		if (cp < UTF8_ONE_LIMIT) begin
			put_res(cp[7:0], ST_DATA);
		end else if (cp < UTF8_TWO_LIMIT) begin
			put_res(UTF8_LEAD2 | 8'(cp >> 6), ST_DATA);
			put_res(UTF8_CONT | {2'b00, cp[5:0] & UTF8_CONT_MASK}, ST_DATA);
		end else begin
			put_res(UTF8_LEAD3 | 8'(cp >> 12), ST_DATA);
			put_res(UTF8_CONT | {2'b00, cp[11:6] & UTF8_CONT_MASK}, ST_DATA);
			put_res(UTF8_CONT | {2'b00, cp[5:0] & UTF8_CONT_MASK}, ST_DATA);
		end
	endfunction

	// Decode one byte into step_q and advance the parser state.
	function automatic void unescape_byte(input logic [7:0] c);
		logic [4:0] nib;
		result_t r;
		step_q.delete();
		if (c == CH_NUL) begin
			put_res(8'h00, ST_UNCLOSED);
			pmode = MODE_SEEK;
			hex_seen = '0;
			cp_acc = '0;
			hex_halted = 1'b0;
		end else begin
			case (pmode)
				MODE_SEEK: begin
					if (c == CH_QUOTE) pmode = MODE_BODY;
				end
				MODE_BODY: begin
					if (c == CH_QUOTE) begin
						put_res(8'h00, ST_CLOSED);
						pmode = MODE_SEEK;
					end else if (c == CH_BSLASH) begin
						pmode = MODE_ESC;
					end else begin
						put_res(c, ST_DATA);
					end
				end
				MODE_ESC: begin
					pmode = MODE_BODY;
					case (c)
						CH_N: put_res(BYTE_LF, ST_DATA);
						CH_R: put_res(BYTE_CR, ST_DATA);
						CH_T: put_res(BYTE_TAB, ST_DATA);
						CH_U: begin
							pmode = MODE_HEX;
							hex_seen = '0;
							cp_acc = '0;
							hex_halted = 1'b0;
						end
						default: put_res(c, ST_DATA);
					endcase
				end
				default: begin
					nib = hex_nibble(c);
					if (!hex_halted) begin
						if (nib[4]) cp_acc = {cp_acc[11:0], nib[3:0]};
						else hex_halted = 1'b1;
					end
					if (hex_seen == 2'd3) begin
						emit_utf8(cp_acc);
						pmode = MODE_BODY;
						hex_seen = '0;
						cp_acc = '0;
						hex_halted = 1'b0;
					end else begin
						hex_seen = hex_seen + 2'd1;
					end
				end
			endcase
		end
		if (step_q.size() > 0) begin
			r = step_q.pop_back();
			r.last = 1'b1;
			step_q.insert(step_q.size(), r);
		end
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 25);
	endfunction

	// Present one byte, hold until accepted, then record its expected results.
	task automatic feed_byte(input logic [7:0] b, input bit typed, input logic [7:0] eb,
			input logic [1:0] est);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		unescape_byte(b);
		if (typed) decoded_q.insert(decoded_q.size(), '{eb, est, 1'b1});
		else foreach (step_q[i]) decoded_q.insert(decoded_q.size(), step_q[i]);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (decoded_q.size() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		if (nib < 4'd10) return "0" + 8'(nib);
		return ($urandom_range(0, 1) ? "A" : "a") + 8'(nib) - 8'd10;
	endfunction

	task automatic push_hex(input int count);
		logic [15:0] cp;
		int cls;
		cls = $urandom_range(0, 2);
		if (cls == 0) cp = 16'($urandom_range(0, 16'h007F));
		else if (cls == 1) cp = 16'($urandom_range(16'h0080, 16'h07FF));
		else cp = 16'($urandom_range(16'h0800, 16'hFFFF));
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 7) == 0)
				stream_q.insert(stream_q.size(), 8'($urandom_range(1, 255)));
			else stream_q.insert(stream_q.size(), hex_char(cp[15 - 4 * i -: 4]));
		end
	endtask

	// Build one string: leading junk, quote, body tokens, then an ending; sometimes noise.
	task automatic gen_string();
		logic [7:0] b;
		int k;
		if ($urandom_range(0, 5) == 0) begin
			repeat ($urandom_range(1, 6))
				stream_q.insert(stream_q.size(), 8'($urandom_range(0, 255)));
			return;
		end
		repeat ($urandom_range(0, 2)) begin
			b = 8'($urandom_range(1, 255));
			if (b == CH_QUOTE) b = CH_APOS;
			stream_q.insert(stream_q.size(), b);
		end
		stream_q.insert(stream_q.size(), CH_QUOTE);
		repeat ($urandom_range(0, 6)) begin
			k = $urandom_range(0, 9);
			if (k < 4) begin
				do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE || b == CH_BSLASH);
				stream_q.insert(stream_q.size(), b);
			end else if (k < 7) begin
				stream_q.insert(stream_q.size(), CH_BSLASH);
				case ($urandom_range(0, 6))
					0: b = CH_QUOTE;
					1: b = CH_BSLASH;
					2: b = CH_SLASH;
					3: b = CH_N;
					4: b = CH_R;
					5: b = CH_T;
					default: b = 8'($urandom_range(1, 255));
				endcase
				stream_q.insert(stream_q.size(), b);
			end else begin
				stream_q.insert(stream_q.size(), CH_BSLASH);
				stream_q.insert(stream_q.size(), CH_U);
				push_hex(4);
			end
		end
		k = $urandom_range(0, 9);
		if (k < 7) begin
			stream_q.insert(stream_q.size(), CH_QUOTE);
		end else if (k == 7) begin
			stream_q.insert(stream_q.size(), CH_NUL);
		end else if (k == 8) begin
			stream_q.insert(stream_q.size(), CH_BSLASH);
			stream_q.insert(stream_q.size(), CH_NUL);
		end else begin
			stream_q.insert(stream_q.size(), CH_BSLASH);
			stream_q.insert(stream_q.size(), CH_U);
			push_hex($urandom_range(0, 3));
			stream_q.insert(stream_q.size(), CH_NUL);
		end
	endtask

	always @(negedge clk) begin : drive_stall
		int r;
		r = $urandom_range(0, 99);
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (calm_left > 0) begin
			calm_left--;
			out_stall <= 1'b0;
		end else if (r < 3) begin
			calm_left = $urandom_range(20, 60);
			out_stall <= 1'b0;
		end else if (r < 6) begin
			stall_left = $urandom_range(8, 25);
			out_stall <= 1'b1;
		end else if (r < 30) begin
			stall_left = $urandom_range(0, 2);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : check_out
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (decoded_q.size() == 0) begin
				report_mismatch("item with none pending", int'({status, out_byte}), 0);
			end else begin
				want = decoded_q.pop_front();
				if (out_byte !== want.data)
					report_mismatch("out_byte", int'(out_byte), int'(want.data));
				if (status !== want.st)
					report_mismatch("status", int'(status), int'(want.st));
				if (run_last !== want.last)
					report_mismatch("run_last", int'(run_last), int'(want.last));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles == IDLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		int sent;
		bit paused;
		in_valid = 1'b0;
		in_byte = 8'h00;
		arst_n = 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		foreach (DIR_ROWS[i])
			feed_byte(DIR_ROWS[i].b, DIR_ROWS[i].typed, DIR_ROWS[i].eb, DIR_ROWS[i].est);
		drain();

		sent = 0;
		paused = 1'b0;
		while (sent < RANDOM_ITEMS) begin
			gen_string();
			no_gaps = ($urandom_range(0, 3) == 0);
			while (stream_q.size() != 0) begin
				feed_byte(stream_q.pop_front(), 1'b0, 8'h00, ST_DATA);
				sent++;
				if (!paused && sent >= RANDOM_ITEMS / 2) begin
					drain();
					paused = 1'b1;
				end
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (errors == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end

endmodule

>>> filelist.f
hdl/jsu_pkg.sv
hdl/jsu_front.sv
hdl/jsu_queue.sv
hdl/jsu_back.sv
hdl/json_string_unescaper.sv
tb/json_string_unescaper_tb.sv
